// ===== rtl/core/mcpl_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpl_pkg: motor current power limiter package
// Widths, stage counts, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpl_pkg;

    // lanes and field widths
    localparam int NLANE      = 4;
    localparam int CUR_W      = 16;
    localparam int MAG_W      = 16;
    localparam int SUM_W      = MAG_W + 2;
    localparam int NUM_W      = SUM_W;
    localparam int DEN_W      = SUM_W;
    localparam int PROD_W     = NUM_W + MAG_W;
    localparam int QUOT_W     = MAG_W;
    localparam int BUF_W      = 10;
    localparam int PWR_W      = 10;
    localparam int VOLT_W     = 6;
    localparam int SLOPE_W    = 10;
    localparam int CAP_W      = 16;
    localparam int SPROD_W    = BUF_W + SLOPE_W;
    localparam int FACT_W     = SPROD_W + 1;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // pipeline depth: front end, then multiply plus one stage per quotient bit
    localparam int FRONT_STAGES = 3;
    localparam int LANE_STAGES  = 1 + QUOT_W;
    localparam int PIPE_STAGES  = FRONT_STAGES + LANE_STAGES;

    // register reset values
    localparam logic [CAP_W-1:0]   OFFLINE_CAP_RST      = 16'd4000;
    localparam logic [CAP_W-1:0]   NORMAL_CAP_RST       = 16'd11000;
    localparam logic [BUF_W-1:0]   BUFFER_THRESHOLD_RST = 10'd20;
    localparam logic [PWR_W-1:0]   POWER_BASELINE_RST   = 10'd80;
    localparam logic [CAP_W-1:0]   FACTOR_BASE_RST      = 16'd2500;
    localparam logic [SLOPE_W-1:0] FACTOR_SLOPE_RST     = 10'd192;
    localparam logic [VOLT_W-1:0]  CAP_VOLTAGE_MIN_RST  = 6'd11;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFLINE_CAP      = 8'd0,
        REG_NORMAL_CAP       = 8'd1,
        REG_BUFFER_THRESHOLD = 8'd2,
        REG_POWER_BASELINE   = 8'd3,
        REG_FACTOR_BASE      = 8'd4,
        REG_FACTOR_SLOPE     = 8'd5,
        REG_CAP_VOLTAGE_MIN  = 8'd6
    } t_cfg_idx;

    // limiting mode reported with each result
    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_OFFLINE = 2'd1,
        MODE_BUFFER  = 2'd2,
        MODE_CAP     = 2'd3
    } t_mode;

    typedef logic signed [CUR_W-1:0] t_cur;
    typedef logic [MAG_W-1:0]        t_mag;

    typedef struct packed {
        logic [CAP_W-1:0]   offline_cap;
        logic [CAP_W-1:0]   normal_cap;
        logic [BUF_W-1:0]   buffer_threshold;
        logic [PWR_W-1:0]   power_baseline;
        logic [CAP_W-1:0]   factor_base;
        logic [SLOPE_W-1:0] factor_slope;
        logic [VOLT_W-1:0]  cap_voltage_min;
    } t_cfg;

    // scaling command shared by all lanes: out = in * num / den when scale
    typedef struct packed {
        logic             scale;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_lane_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/mcpl_front.sv =====
// ----------------------------------------------------------------------------
// mcpl_front: magnitude sum and mode selection
// Three stages: magnitudes, sum and mode decision, scale numerator/divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpl_front
    import mcpl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [FRONT_STAGES-1:0] i_en,
    input  wire t_cfg                    i_cfg,
    input  wire t_cur                    i_cur [NLANE],
    input  wire logic                    i_offline,
    input  wire logic [BUF_W-1:0]        i_buffer,
    input  wire logic [PWR_W-1:0]        i_power,
    input  wire logic                    i_releasing,
    input  wire logic [VOLT_W-1:0]       i_volts,
    output t_lane_cmd                    o_cmd,
    output t_cur                         o_cur [NLANE],
    output t_mag                         o_mag [NLANE],
    output t_mode                        o_mode
);

    // stage 0 registers
    t_cur              r_s0_cur [NLANE];
    t_mag              r_s0_mag [NLANE];
    logic              r_s0_offline;
    logic [BUF_W-1:0]  r_s0_buffer;
    logic [PWR_W-1:0]  r_s0_power;
    logic              r_s0_releasing;
    logic [VOLT_W-1:0] r_s0_volts;

    // stage 1 registers
    t_cur               r_s1_cur [NLANE];
    t_mag               r_s1_mag [NLANE];
    logic [SUM_W-1:0]   r_s1_sum;
    logic [SPROD_W-1:0] r_s1_sprod;
    t_mode              r_s1_mode;

    // stage 2 registers
    t_cur      r_s2_cur [NLANE];
    t_mag      r_s2_mag [NLANE];
    t_lane_cmd r_s2_cmd;
    t_mode     r_s2_mode;

    // stage 1 logic
    logic [SUM_W-1:0]          n_sum;
    logic [PWR_W-1:0]          excess;
    logic signed [BUF_W+1:0]   margin;
    logic                      buffer_low;
    t_mode                     n_mode;
    logic [SPROD_W-1:0]        n_sprod;

    // stage 2 logic
    logic [FACT_W-1:0] factor;
    logic [NUM_W-1:0]  factor_lim;
    t_lane_cmd         n_cmd;

    // stage 0: capture the beat, take magnitudes (0x8000 reads as 32768)
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int l = 0; l < NLANE; l++) begin
                r_s0_cur[l] <= i_cur[l];
                r_s0_mag[l] <= i_cur[l][CUR_W-1] ? t_mag'(-i_cur[l]) : t_mag'(i_cur[l]);
            end
            r_s0_offline   <= i_offline;
            r_s0_buffer    <= i_buffer;
            r_s0_power     <= i_power;
            r_s0_releasing <= i_releasing;
            r_s0_volts     <= i_volts;
        end
    end

    // stage 1: exact sum, buffer margin and mode priority
    always_comb begin
        n_sum = '0;
        for (int l = 0; l < NLANE; l++) begin
            n_sum = n_sum + SUM_W'(r_s0_mag[l]);
        end
        excess = (r_s0_power > i_cfg.power_baseline) ?
                 r_s0_power - i_cfg.power_baseline : '0;
        margin = $signed({2'b00, r_s0_buffer}) - $signed({2'b00, excess});
        buffer_low = margin < $signed({2'b00, i_cfg.buffer_threshold});
        if (r_s0_offline) begin
            n_mode = MODE_OFFLINE;
        end else if (buffer_low) begin
            n_mode = MODE_BUFFER;
        end else if (!r_s0_releasing || (r_s0_volts < i_cfg.cap_voltage_min)) begin
            n_mode = MODE_CAP;
        end else begin
            n_mode = MODE_NONE;
        end
        n_sprod = SPROD_W'(r_s0_buffer) * SPROD_W'(i_cfg.factor_slope);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_cur   <= r_s0_cur;
            r_s1_mag   <= r_s0_mag;
            r_s1_sum   <= n_sum;
            r_s1_sprod <= n_sprod;
            r_s1_mode  <= n_mode;
        end
    end

    // stage 2: numerator, divisor and whether scaling applies
    always_comb begin
        factor     = FACT_W'(i_cfg.factor_base) + FACT_W'(r_s1_sprod);
        factor_lim = (factor > FACT_W'(r_s1_sum)) ? r_s1_sum : factor[NUM_W-1:0];
        n_cmd.den  = r_s1_sum;
        case (r_s1_mode)
            MODE_OFFLINE: begin
                n_cmd.scale = r_s1_sum > SUM_W'(i_cfg.offline_cap);
                n_cmd.num   = NUM_W'(i_cfg.offline_cap);
                n_cmd.den   = r_s1_sum + DEN_W'(1);
            end
            MODE_BUFFER: begin
                // zero sum means all currents are zero, pass them through
                n_cmd.scale = r_s1_sum != '0;
                n_cmd.num   = factor_lim;
            end
            MODE_CAP: begin
                n_cmd.scale = r_s1_sum > SUM_W'(i_cfg.normal_cap);
                n_cmd.num   = NUM_W'(i_cfg.normal_cap);
            end
            default: begin
                n_cmd.scale = 1'b0;
                n_cmd.num   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_cur  <= r_s1_cur;
            r_s2_mag  <= r_s1_mag;
            r_s2_cmd  <= n_cmd;
            r_s2_mode <= r_s1_mode;
        end
    end

    assign o_cmd  = r_s2_cmd;
    assign o_cur  = r_s2_cur;
    assign o_mag  = r_s2_mag;
    assign o_mode = r_s2_mode;

endmodule

`default_nettype wire

// ===== rtl/core/mcpl_lane.sv =====
// ----------------------------------------------------------------------------
// mcpl_lane: one current lane
// Registered multiply, then a restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpl_lane
    import mcpl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic [LANE_STAGES-1:0] i_en,
    input  wire t_lane_cmd              i_cmd,
    input  wire t_cur                   i_cur,
    input  wire t_mag                   i_mag,
    output t_cur                        o_result
);

    // multiply stage
    logic [PROD_W-1:0] r_m_prod;
    logic [DEN_W-1:0]  r_m_den;
    logic              r_m_scale;
    t_cur              r_m_cur;

    // divider stages
    logic [PROD_W-1:0] r_rem   [QUOT_W];
    logic [QUOT_W-1:0] r_quot  [QUOT_W];
    logic [DEN_W-1:0]  r_den   [QUOT_W];
    logic              r_scale [QUOT_W];
    t_cur              r_cur   [QUOT_W];

    logic [QUOT_W-1:0] quot;

    // |I| * num, below den << QUOT_W whenever scaling applies
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_m_prod  <= PROD_W'(i_mag) * PROD_W'(i_cmd.num);
            r_m_den   <= i_cmd.den;
            r_m_scale <= i_cmd.scale;
            r_m_cur   <= i_cur;
        end
    end

    // quotient bits from the top down
    for (genvar j = 0; j < QUOT_W; j++) begin : g_div
        localparam int B = QUOT_W - 1 - j;
        logic [PROD_W-1:0] rem_in;
        logic [QUOT_W-1:0] quot_in;
        logic [DEN_W-1:0]  den_in;
        logic              scale_in;
        t_cur              cur_in;
        logic [PROD_W-1:0] trial;
        logic              fits;

        if (j == 0) begin : g_first
            assign rem_in   = r_m_prod;
            assign quot_in  = '0;
            assign den_in   = r_m_den;
            assign scale_in = r_m_scale;
            assign cur_in   = r_m_cur;
        end else begin : g_next
            assign rem_in   = r_rem[j-1];
            assign quot_in  = r_quot[j-1];
            assign den_in   = r_den[j-1];
            assign scale_in = r_scale[j-1];
            assign cur_in   = r_cur[j-1];
        end

        assign trial = PROD_W'(den_in) << B;
        assign fits  = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en[1+j]) begin
                r_rem[j]   <= fits ? rem_in - trial : rem_in;
                r_quot[j]  <= quot_in | (QUOT_W'(fits) << B);
                r_den[j]   <= den_in;
                r_scale[j] <= scale_in;
                r_cur[j]   <= cur_in;
            end
        end
    end

    // restore sign, or pass the command unchanged
    assign quot = r_quot[QUOT_W-1];
    always_comb begin
        if (!r_scale[QUOT_W-1]) begin
            o_result = r_cur[QUOT_W-1];
        end else if (r_cur[QUOT_W-1][CUR_W-1]) begin
            o_result = t_cur'(QUOT_W'(0) - quot);
        end else begin
            o_result = t_cur'(quot);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/motor_current_power_limiter.sv =====
// ----------------------------------------------------------------------------
// motor_current_power_limiter: four wheel current power limiter
// Scales the four current commands together against the power budget.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        sink       i_in_valid / o_in_ready     currents, power status
//  out       source     o_out_valid / i_out_ready   limited currents, mode
//  cfg       sink       i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  One beat per cycle sustained while the output is ready; registers in
//  order: three front stages, one multiply stage, sixteen divider stages
//  (one quotient bit each, four lanes in parallel) and the output register.
//  Synchronous active-low reset clears stage valids and loads register
//  defaults. A stalled output only blocks stages that are full; bubbles
//  collapse, so input is taken while a result waits unless every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_current_power_limiter
    import mcpl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [CUR_W-1:0]      i_current_fl,
    input  wire logic [CUR_W-1:0]      i_current_fr,
    input  wire logic [CUR_W-1:0]      i_current_bl,
    input  wire logic [CUR_W-1:0]      i_current_br,
    input  wire logic                  i_referee_offline,
    input  wire logic [BUF_W-1:0]      i_power_buffer,
    input  wire logic [PWR_W-1:0]      i_drive_power,
    input  wire logic                  i_cap_releasing,
    input  wire logic [VOLT_W-1:0]     i_cap_voltage,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [CUR_W-1:0]           o_limited_fl,
    output logic [CUR_W-1:0]           o_limited_fr,
    output logic [CUR_W-1:0]           o_limited_bl,
    output logic [CUR_W-1:0]           o_limited_br,
    output logic [1:0]                 o_mode_taken
);

    t_cfg                   r_cfg;
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] stage_en;
    logic                   out_blocked;
    logic                   out_load;

    t_cur      in_cur   [NLANE];
    t_cur      front_cur [NLANE];
    t_mag      front_mag [NLANE];
    t_lane_cmd front_cmd;
    t_mode     front_mode;
    t_cur      lane_res [NLANE];
    t_mode     r_mode_line [LANE_STAGES];

    logic  r_out_valid;
    t_cur  r_out_cur [NLANE];
    t_mode r_out_mode;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offline_cap      <= OFFLINE_CAP_RST;
            r_cfg.normal_cap       <= NORMAL_CAP_RST;
            r_cfg.buffer_threshold <= BUFFER_THRESHOLD_RST;
            r_cfg.power_baseline   <= POWER_BASELINE_RST;
            r_cfg.factor_base      <= FACTOR_BASE_RST;
            r_cfg.factor_slope     <= FACTOR_SLOPE_RST;
            r_cfg.cap_voltage_min  <= CAP_VOLTAGE_MIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OFFLINE_CAP:      r_cfg.offline_cap      <= i_cfg_data[CAP_W-1:0];
                REG_NORMAL_CAP:       r_cfg.normal_cap       <= i_cfg_data[CAP_W-1:0];
                REG_BUFFER_THRESHOLD: r_cfg.buffer_threshold <= i_cfg_data[BUF_W-1:0];
                REG_POWER_BASELINE:   r_cfg.power_baseline   <= i_cfg_data[PWR_W-1:0];
                REG_FACTOR_BASE:      r_cfg.factor_base      <= i_cfg_data[CAP_W-1:0];
                REG_FACTOR_SLOPE:     r_cfg.factor_slope     <= i_cfg_data[SLOPE_W-1:0];
                REG_CAP_VOLTAGE_MIN:  r_cfg.cap_voltage_min  <= i_cfg_data[VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage k moves unless it and every stage after it are full and out stalls
    assign out_blocked = r_out_valid && !i_out_ready;
    assign out_load    = !out_blocked;
    always_comb begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            stage_en[k] = !(out_blocked &&
                            (&(r_vld | ~({PIPE_STAGES{1'b1}} << k))));
        end
    end
    assign o_in_ready = stage_en[0];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < PIPE_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign in_cur[0] = i_current_fl;
    assign in_cur[1] = i_current_fr;
    assign in_cur[2] = i_current_bl;
    assign in_cur[3] = i_current_br;

    mcpl_front u_front (
        .i_clk       (i_clk),
        .i_en        (stage_en[FRONT_STAGES-1:0]),
        .i_cfg       (r_cfg),
        .i_cur       (in_cur),
        .i_offline   (i_referee_offline),
        .i_buffer    (i_power_buffer),
        .i_power     (i_drive_power),
        .i_releasing (i_cap_releasing),
        .i_volts     (i_cap_voltage),
        .o_cmd       (front_cmd),
        .o_cur       (front_cur),
        .o_mag       (front_mag),
        .o_mode      (front_mode)
    );

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        mcpl_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (stage_en[PIPE_STAGES-1:FRONT_STAGES]),
            .i_cmd    (front_cmd),
            .i_cur    (front_cur[l]),
            .i_mag    (front_mag[l]),
            .o_result (lane_res[l])
        );
    end

    // mode travels beside the lanes
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANE_STAGES; k++) begin
            if (stage_en[FRONT_STAGES+k]) begin
                r_mode_line[k] <= (k == 0) ? front_mode : r_mode_line[(k == 0) ? 0 : k-1];
            end
        end
    end

    // merge lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_vld[PIPE_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_cur  <= lane_res;
            r_out_mode <= r_mode_line[LANE_STAGES-1];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_limited_fl = r_out_cur[0];
    assign o_limited_fr = r_out_cur[1];
    assign o_limited_bl = r_out_cur[2];
    assign o_limited_br = r_out_cur[3];
    assign o_mode_taken = r_out_mode;

endmodule

`default_nettype wire

// ===== rtl/core/mcpl_checker.sv =====
// ----------------------------------------------------------------------------
// mcpl_checker: port level checks for the current limiter
// Output hold under stall, reset behavior and input acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_limited_fl,
    input wire logic [15:0] o_limited_fr,
    input wire logic [15:0] o_limited_bl,
    input wire logic [15:0] o_limited_br,
    input wire logic [1:0]  o_mode_taken
);

    // a stalled result beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_limited_fl) && $stable(o_limited_fr) &&
            $stable(o_limited_bl) && $stable(o_limited_br) &&
            $stable(o_mode_taken))
        else $error("output payload changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // with no result waiting, the pipeline can always take a beat
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a beat taken with the output empty: next cycle the input is ready or a result waits
    a_in_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> o_in_ready || o_out_valid)
        else $error("input stalled without a waiting result");

endmodule

bind motor_current_power_limiter mcpl_checker u_mcpl_checker (.*);

`default_nettype wire
